/* hw/rtl/plir_pkg.sv */
package plir_pkg;

    localparam int PLIR_DEPTH = 64;

    localparam int POS_W   = 7;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef struct packed {
        logic signed [VAL_W-1:0] first;
        logic signed [VAL_W-1:0] second;
    } pair_t;

    // Shift command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } shift_cmd_t;

endpackage

/* hw/rtl/plir_cell.sv */
module plir_cell #(
    parameter int IDX = 0,
    parameter int PW  = 7
) (
    input  logic                clk,
    input  plir_pkg::shift_cmd_t cmd,
    input  logic [PW-1:0]       pos,
    input  plir_pkg::pair_t     new_pair,
    input  plir_pkg::pair_t     lower_pair,
    input  plir_pkg::pair_t     upper_pair,
    output plir_pkg::pair_t     pair_q
);

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    plir_pkg::pair_t pair_reg;
    plir_pkg::pair_t pair_next;

    always_comb
    begin
        pair_next = pair_reg;
        if (cmd.ins)
        begin
            // open a slot: cells above the position take the lower neighbor
            if (MY_IDX > pos)
            begin
                pair_next = lower_pair;
            end
            else if (MY_IDX == pos)
            begin
                pair_next = new_pair;
            end
        end
        else if (cmd.rem)
        begin
            // close the gap: cells at and above the position take the upper neighbor
            if (MY_IDX >= pos)
            begin
                pair_next = upper_pair;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pair_reg <= pair_next;
    end

    assign pair_q = pair_reg;

endmodule

/* hw/rtl/pair_list_insert_remove.sv */
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | action, position, first_value, second_value
// out     | output    | out_valid / out_ready| status, removed_first, removed_second, entry_count
//
// Rate: one item per clock while out_ready is high; the result shows in the cycle after the input beat.
// Every cell decides shift, load or hold in parallel from its index and the
// position, so the whole row of cells updates together for one operation.
// Reset clears the entry count and the output valid; stored pairs are not cleared.
// Stalls: in_ready drops only while a result waits and out_ready is low.
module pair_list_insert_remove #(
    parameter int DEPTH = plir_pkg::PLIR_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               action,
    input  logic [plir_pkg::POS_W-1:0]         position,
    input  logic signed [plir_pkg::VAL_W-1:0]  first_value,
    input  logic signed [plir_pkg::VAL_W-1:0]  second_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [plir_pkg::STAT_W-1:0]        status,
    output logic signed [plir_pkg::VAL_W-1:0]  removed_first,
    output logic signed [plir_pkg::VAL_W-1:0]  removed_second,
    output logic [plir_pkg::POS_W-1:0]         entry_count
);

    // Width of the entry count and of the compare width shared with position
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > plir_pkg::POS_W) ? CW : plir_pkg::POS_W;

    logic                        accept;
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic                        out_valid_reg;
    logic [plir_pkg::STAT_W-1:0] status_reg;
    logic [plir_pkg::STAT_W-1:0] status_next;
    plir_pkg::pair_t             removed_reg;
    plir_pkg::pair_t             removed_next;
    logic [plir_pkg::POS_W-1:0]  entry_count_reg;
    logic [PW-1:0]               pos_x;
    logic [PW-1:0]               count_x;
    logic [PW-1:0]               count_next_x;
    plir_pkg::shift_cmd_t        cmd;
    plir_pkg::pair_t             new_pair;
    plir_pkg::pair_t             cell_q [DEPTH];
    plir_pkg::pair_t             sel_pair;

    // Take a new beat whenever the output register is free or draining
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign pos_x    = PW'(position);
    assign count_x  = PW'(count_reg);
    assign new_pair = '{first: first_value, second: second_value};

    // Classify the beat: insert, remove or error with no state change
    always_comb
    begin
        status_next = plir_pkg::ST_OK;
        cmd         = '{ins: 1'b0, rem: 1'b0};
        count_next  = count_reg;
        if (action == plir_pkg::ACT_INSERT)
        begin
            if (count_reg == CW'(DEPTH))
            begin
                status_next = plir_pkg::ST_FULL;
            end
            else if (pos_x > count_x)
            begin
                status_next = plir_pkg::ST_BAD;
            end
            else
            begin
                cmd.ins    = accept;
                count_next = count_reg + CW'(1);
            end
        end
        else
        begin
            // position at or past the count also covers the empty list
            if (pos_x >= count_x)
            begin
                status_next = plir_pkg::ST_BAD;
            end
            else
            begin
                cmd.rem    = accept;
                count_next = count_reg - CW'(1);
            end
        end
    end

    // Row of cells; each cell sees its two neighbors at fixed places
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        plir_pkg::pair_t lower_pair;
        plir_pkg::pair_t upper_pair;

        if (i == 0)
        begin : g_first
            assign lower_pair = new_pair;
        end
        else
        begin : g_mid_lo
            assign lower_pair = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign upper_pair = new_pair;
        end
        else
        begin : g_mid_hi
            assign upper_pair = cell_q[i+1];
        end

        plir_cell #(
            .IDX (i),
            .PW  (PW)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .pos        (pos_x),
            .new_pair   (new_pair),
            .lower_pair (lower_pair),
            .upper_pair (upper_pair),
            .pair_q     (cell_q[i])
        );
    end

    // Pick the pair at the position with an AND-OR select across the cells
    always_comb
    begin
        sel_pair = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (PW'(i) == pos_x)
            begin
                sel_pair = sel_pair | cell_q[i];
            end
        end
    end

    assign removed_next = (action == plir_pkg::ACT_REMOVE && status_next == plir_pkg::ST_OK)
                          ? sel_pair : '0;
    assign count_next_x = PW'(count_next);

    // Control state: entry count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on every accepted beat, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status_next;
            removed_reg     <= removed_next;
            entry_count_reg <= count_next_x[plir_pkg::POS_W-1:0];
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign removed_first  = removed_reg.first;
    assign removed_second = removed_reg.second;
    assign entry_count    = entry_count_reg;

    // The list never holds more than the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    // Every accepted beat shows a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted beat produced no result");

    // An error result carries a zero pair
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != plir_pkg::ST_OK)
        |-> (removed_reg == '0))
        else $error("error result with nonzero pair");

    // An error beat leaves the count unchanged
    a_error_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status_next != plir_pkg::ST_OK) |=> (count_reg == $past(count_reg)))
        else $error("error beat changed the count");

endmodule
